>>> hdl/ism_pkg.sv
`timescale 1ns / 1ps

package ism_pkg;

    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 11;
    localparam int DEPTH_DEF = 1024;

    typedef enum logic [MODE_W-1:0] {
        MODE_HALT    = 3'd0,
        MODE_ADD     = 3'd1,
        MODE_SUB     = 3'd2,
        MODE_MUL     = 3'd3,
        MODE_DIV     = 3'd4,
        MODE_PUSH    = 3'd5,
        MODE_POP     = 3'd6,
        MODE_UNKNOWN = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_HALT  = 3'd1,
        ST_UNDER = 3'd2,
        ST_OVER  = 3'd3,
        ST_DIVZ  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [1:0] {
        AS_IDLE,
        AS_DIV,
        AS_FIX
    } alu_state_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DECODE,
        SQ_POP,
        SQ_READ2,
        SQ_LOAD,
        SQ_CALC,
        SQ_FINISH
    } seq_state_t;

endpackage

>>> hdl/ism_ram.sv
`timescale 1ns / 1ps

module ism_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/ism_alu.sv
`timescale 1ns / 1ps

module ism_alu import ism_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  alu_req_t          req,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic              done,
    output logic [DATA_W-1:0] y
);

    localparam int CNT_W = $clog2(DATA_W);

    alu_state_t        state_reg, state_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] y_reg, y_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dmag_reg, dmag_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [DATA_W-1:0] mul_lo;
    logic [DATA_W:0]   rem_shift;
    logic              ge;

    assign mul_lo    = a * b;
    assign rem_shift = {rem_reg, q_reg[DATA_W-1]};
    assign ge        = rem_shift >= {1'b0, dmag_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        y_reg    <= y_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
    end

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        y_next     = y_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        dmag_next  = dmag_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            AS_IDLE: begin
                if (req.start) begin
                    unique case (req.op)
                        OP_ADD: begin
                            y_next    = a + b;
                            done_next = 1'b1;
                        end
                        OP_SUB: begin
                            y_next    = a - b;
                            done_next = 1'b1;
                        end
                        OP_MUL: begin
                            y_next    = mul_lo;
                            done_next = 1'b1;
                        end
                        OP_DIV: begin
                            // divide magnitudes, fix the sign at the end
                            q_next     = a[DATA_W-1] ? (~a + 1'b1) : a;
                            dmag_next  = b[DATA_W-1] ? (~b + 1'b1) : b;
                            neg_next   = a[DATA_W-1] ^ b[DATA_W-1];
                            rem_next   = '0;
                            cnt_next   = CNT_W'(DATA_W - 1);
                            state_next = AS_DIV;
                        end
                    endcase
                end
            end
            AS_DIV: begin
                // one restoring step per cycle, quotient bits shift into q
                if (ge) begin
                    rem_next = DATA_W'(rem_shift - {1'b0, dmag_reg});
                end else begin
                    rem_next = rem_shift[DATA_W-1:0];
                end
                q_next   = {q_reg[DATA_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = AS_FIX;
                end
            end
            AS_FIX: begin
                y_next     = neg_reg ? (~q_reg + 1'b1) : q_reg;
                done_next  = 1'b1;
                state_next = AS_IDLE;
            end
            default: begin
                state_next = AS_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

>>> hdl/integer_stack_machine_unit.sv
`timescale 1ns / 1ps

// Channel  | Direction | Ports                               | Transfer when
// ---------+-----------+-------------------------------------+-------------------
// input    | in        | s_valid s_ready s_mode s_operand    | s_valid & s_ready
// result   | out       | m_valid m_ready m_result m_status   | m_valid & m_ready
//          |           | m_depth                             |
//
// One instruction at a time: s_ready is high only while the sequencer idles.
// Divide time is set by the shared ALU's one-bit-per-cycle divide loop.
// Stack reads go through the RAM's registered read port, one operand a cycle.
// Reset (aresetn low, synchronous) empties the stack; RAM contents stay as they are.
// A stalled result holds in the output register; the next instruction is taken
// meanwhile and waits in its finish step until the register frees up.

module integer_stack_machine_unit import ism_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [DATA_W-1:0]   s_operand,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DATA_W-1:0]   m_result,
    output logic [STATUS_W-1:0] m_status,
    output logic [DEPTH_W-1:0]  m_depth
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);
    localparam int DW = (PW > DEPTH_W) ? PW : DEPTH_W;

    seq_state_t        state_reg, state_next;
    logic [PW-1:0]     sp_reg, sp_next;
    mode_t             mode_reg;
    logic [DATA_W-1:0] operand_reg;
    logic [DATA_W-1:0] top_reg;
    logic [DATA_W-1:0] res_reg, res_next;
    status_t           status_reg, status_next;

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_result_reg;
    status_t           m_status_reg;
    logic [DEPTH_W-1:0] m_depth_reg;
    logic              out_load;

    logic [PW-1:0]     sp_m1, sp_m2;
    logic [DW-1:0]     sp_wide;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    alu_req_t          alu_req;
    logic              alu_done;
    logic [DATA_W-1:0] alu_y;

    logic              in_xfer;

    assign sp_m1   = sp_reg - PW'(1);
    assign sp_m2   = sp_reg - PW'(2);
    assign sp_wide = DW'(sp_reg);
    assign in_xfer = s_valid && s_ready;

    ism_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ism_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (ram_rdata),
        .b       (top_reg),
        .done    (alu_done),
        .y       (alu_y)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SQ_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            mode_reg    <= mode_t'(s_mode);
            operand_reg <= s_operand;
        end
        if (state_reg == SQ_READ2) begin
            top_reg <= ram_rdata;
        end
        res_reg    <= res_next;
        status_reg <= status_next;
        if (out_load) begin
            m_result_reg <= res_reg;
            m_status_reg <= status_reg;
            m_depth_reg  <= sp_wide[DEPTH_W-1:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        sp_next       = sp_reg;
        res_next      = res_reg;
        status_next   = status_reg;
        s_ready       = 1'b0;
        out_load      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = sp_reg[AW-1:0];
        ram_wdata     = operand_reg;
        ram_raddr     = sp_m1[AW-1:0];
        alu_req.start = 1'b0;
        alu_req.op    = OP_ADD;

        unique case (state_reg)
            SQ_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = SQ_DECODE;
                end
            end
            SQ_DECODE: begin
                state_next  = SQ_FINISH;
                res_next    = '0;
                status_next = ST_OK;
                unique case (mode_reg)
                    MODE_PUSH: begin
                        if (sp_reg == PW'(DEPTH)) begin
                            status_next = ST_OVER;
                        end else begin
                            ram_we   = 1'b1;
                            sp_next  = sp_reg + PW'(1);
                            res_next = operand_reg;
                        end
                    end
                    MODE_POP: begin
                        if (sp_reg == '0) begin
                            status_next = ST_UNDER;
                        end else begin
                            // top is read at sp - 1; data arrives next cycle
                            sp_next    = sp_m1;
                            state_next = SQ_POP;
                        end
                    end
                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                        if (sp_reg < PW'(2)) begin
                            status_next = ST_UNDER;
                        end else begin
                            state_next = SQ_READ2;
                        end
                    end
                    MODE_HALT, MODE_UNKNOWN: begin
                        res_next    = '1;
                        status_next = ST_HALT;
                    end
                endcase
            end
            SQ_POP: begin
                res_next   = ram_rdata;
                state_next = SQ_FINISH;
            end
            SQ_READ2: begin
                // top lands now; fetch the second operand
                ram_raddr  = sp_m2[AW-1:0];
                state_next = SQ_LOAD;
            end
            SQ_LOAD: begin
                if (mode_reg == MODE_DIV && top_reg == '0) begin
                    res_next    = '0;
                    status_next = ST_DIVZ;
                    state_next  = SQ_FINISH;
                end else begin
                    alu_req.start = 1'b1;
                    unique case (mode_reg)
                        MODE_SUB: alu_req.op = OP_SUB;
                        MODE_MUL: alu_req.op = OP_MUL;
                        MODE_DIV: alu_req.op = OP_DIV;
                        default:  alu_req.op = OP_ADD;
                    endcase
                    state_next = SQ_CALC;
                end
            end
            SQ_CALC: begin
                // drop two operands, write the result over the second
                if (alu_done) begin
                    ram_we      = 1'b1;
                    ram_waddr   = sp_m2[AW-1:0];
                    ram_wdata   = alu_y;
                    sp_next     = sp_m1;
                    res_next    = alu_y;
                    status_next = ST_OK;
                    state_next  = SQ_FINISH;
                end
            end
            SQ_FINISH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = SQ_IDLE;
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;
    assign m_status = m_status_reg;
    assign m_depth  = m_depth_reg;

endmodule

>>> sim/integer_stack_machine_checker.sv
`timescale 1ns / 1ps

module integer_stack_machine_checker import ism_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [DATA_W-1:0]   s_operand,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [DATA_W-1:0]   m_result,
    input  logic [STATUS_W-1:0] m_status,
    input  logic [DEPTH_W-1:0]  m_depth,
    output int                  fail_count,
    output int                  pending_count
);

    typedef struct packed {
        logic [DATA_W-1:0]  result;
        status_t            status;
        logic [DEPTH_W-1:0] depth;
    } outcome_t;

    logic [DATA_W-1:0] operand_stack [DEPTH];
    int unsigned       stack_top;
    outcome_t          outcome_q [$];
    int unsigned       result_idx;

    // Truncating signed divide on raw patterns; the minimum over minus one wraps.
    function automatic logic [DATA_W-1:0] quotient_trunc(logic [DATA_W-1:0] num,
                                                         logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] num_mag;
        logic [DATA_W-1:0] den_mag;
        logic [DATA_W-1:0] quo;
        num_mag = num[DATA_W-1] ? -num : num;
        den_mag = den[DATA_W-1] ? -den : den;
        quo     = num_mag / den_mag;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quo : quo;
    endfunction

    function automatic outcome_t execute_instruction(mode_t op, logic [DATA_W-1:0] operand);
        outcome_t          o;
        logic [DATA_W-1:0] top_val;
        logic [DATA_W-1:0] second_val;
        o.result = '0;
        o.status = ST_OK;
        case (op)
            MODE_PUSH: begin
                if (stack_top >= DEPTH) begin
                    o.status = ST_OVER;
                end else begin
                    operand_stack[stack_top] = operand;
                    stack_top++;
                    o.result = operand;
                end
            end
            MODE_POP: begin
                if (stack_top == 0) begin
                    o.status = ST_UNDER;
                end else begin
                    stack_top--;
                    o.result = operand_stack[stack_top];
                end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                if (stack_top < 2) begin
                    o.status = ST_UNDER;
                end else begin
                    top_val    = operand_stack[stack_top-1];
                    second_val = operand_stack[stack_top-2];
                    if (op == MODE_DIV && top_val == '0) begin
                        o.status = ST_DIVZ;
                    end else begin
                        case (op)
                            MODE_ADD: o.result = second_val + top_val;
                            MODE_SUB: o.result = second_val - top_val;
                            MODE_MUL: o.result = second_val * top_val;
                            default:  o.result = quotient_trunc(second_val, top_val);
                        endcase
                        stack_top--;
                        operand_stack[stack_top-1] = o.result;
                    end
                end
            end
            default: begin
                o.result = '1;
                o.status = ST_HALT;
            end
        endcase
        o.depth = DEPTH_W'(stack_top);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("[%0t] result %0d: %s got %h want %h", $time, result_idx, what, got, want);
        fail_count++;
    endtask

    // Check the result transfer first: it can never belong to an instruction
    // taken at the same edge.
    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            stack_top  = 0;
            result_idx = 0;
            fail_count = 0;
            outcome_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("unexpected result", m_result, 'x);
                end else begin
                    want = outcome_q.pop_front();
                    if (m_result !== want.result)
                        report_mismatch("result", m_result, want.result);
                    if (m_status !== want.status)
                        report_mismatch("status", DATA_W'(m_status), DATA_W'(want.status));
                    if (m_depth !== want.depth)
                        report_mismatch("depth", DATA_W'(m_depth), DATA_W'(want.depth));
                end
                result_idx++;
            end
            if (s_valid && s_ready)
                outcome_q.push_back(execute_instruction(mode_t'(s_mode), s_operand));
        end
        pending_count <= outcome_q.size();
    end

endmodule

>>> sim/tb_integer_stack_machine_unit.sv
`timescale 1ns / 1ps

module tb_integer_stack_machine_unit import ism_pkg::*; ();

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic [MODE_W-1:0]   s_mode    = MODE_HALT;
    logic [DATA_W-1:0]   s_operand = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [DATA_W-1:0]   m_result;
    logic [STATUS_W-1:0] m_status;
    logic [DEPTH_W-1:0]  m_depth;
    int                  fail_count;
    int                  pending_count;

    // Items left in the current back-to-back burst on the input side.
    int                  burst_items = 0;

    integer_stack_machine_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_operand (s_operand),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .m_status  (m_status),
        .m_depth   (m_depth)
    );

    // The checker watches both channels, keeps its own copy of the stack and
    // counts mismatches; this module only drives stimulus and calls the verdict.
    integer_stack_machine_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_operand     (s_operand),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result      (m_result),
        .m_status      (m_status),
        .m_depth       (m_depth),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: roughly ten times the slowest legal run (about 850
    // instructions, each with a long divide, a long result stall and a long gap).
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Idle cycles after a transfer: mostly none or short, now and then long.
    // Occasionally start a burst of back-to-back instructions.
    function automatic int pick_gap();
        int unsigned sel;
        if (burst_items > 0) begin
            burst_items--;
            return 0;
        end
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
            burst_items = $urandom_range(20, 40);
            return 0;
        end
        if (sel < 50) return 0;
        if (sel < 85) return $urandom_range(1, 3);
        if (sel < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Operand mix: extremes, tiny values (so divides hit zero and small
    // quotients), mid-size values and full random patterns.
    function automatic logic [DATA_W-1:0] pick_operand();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            case ($urandom_range(0, 4))
                0:       return {1'b1, {(DATA_W-1){1'b0}}};
                1:       return {1'b0, {(DATA_W-1){1'b1}}};
                2:       return '0;
                3:       return '1;
                default: return DATA_W'(1);
            endcase
        end
        if (sel < 45) return DATA_W'(int'($urandom_range(0, 14)) - 7);
        if (sel < 60) return DATA_W'(int'($urandom_range(0, 131070)) - 65535);
        return $urandom();
    endfunction

    // Net pops slightly outnumber the pushes, so the stack hovers at a shallow
    // depth with real arithmetic and the odd underflow; halt and unknown are noise.
    function automatic mode_t pick_mode();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) return MODE_PUSH;
        if (sel < 53) return MODE_POP;
        if (sel < 63) return MODE_ADD;
        if (sel < 72) return MODE_SUB;
        if (sel < 81) return MODE_MUL;
        if (sel < 93) return MODE_DIV;
        if (sel < 97) return MODE_HALT;
        return MODE_UNKNOWN;
    endfunction

    // Present one instruction and hold it until the transfer; call at a rising edge.
    // Valid stays high when no gap follows, so the next call just updates the payload.
    task automatic send_instruction(mode_t op, logic [DATA_W-1:0] operand);
        int gap;
        s_valid   <= 1'b1;
        s_mode    <= op;
        s_operand <= operand;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop sending and wait until every predicted result has been taken.
    // Step one edge first so the checker has counted the last transfer.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++) begin
            send_instruction(pick_mode(), pick_operand());
            if (i % 150 == 149) wait_drained();
        end
    endtask

    // Result side: ready runs of random length broken by stalls; a few very
    // long ready runs give stretches with no back-pressure at all.
    initial begin : result_ready_gen
        int run_len;
        int unsigned sel;
        while (!aresetn) @(posedge aclk);
        forever begin
            sel = $urandom_range(0, 99);
            if (sel < 70)      run_len = $urandom_range(1, 6);
            else if (sel < 95) run_len = $urandom_range(7, 30);
            else               run_len = $urandom_range(100, 300);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            sel = $urandom_range(0, 99);
            if (sel < 40)      run_len = 0;
            else if (sel < 85) run_len = $urandom_range(1, 3);
            else if (sel < 97) run_len = $urandom_range(4, 12);
            else               run_len = $urandom_range(20, 50);
            if (run_len > 0) begin
                m_ready <= 1'b0;
                repeat (run_len) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
        localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: halt and unknown, underflow on an empty and a one-deep
        // stack, extremes, divide by zero, minimum over minus one, truncation.
        send_instruction(MODE_HALT, $urandom());
        send_instruction(MODE_UNKNOWN, $urandom());
        send_instruction(MODE_POP, $urandom());
        send_instruction(MODE_ADD, $urandom());
        send_instruction(MODE_PUSH, MAX_VAL);
        send_instruction(MODE_DIV, $urandom());
        send_instruction(MODE_PUSH, MIN_VAL);
        send_instruction(MODE_ADD, $urandom());
        send_instruction(MODE_PUSH, '0);
        send_instruction(MODE_DIV, $urandom());
        send_instruction(MODE_SUB, $urandom());
        send_instruction(MODE_PUSH, MIN_VAL);
        send_instruction(MODE_PUSH, '1);
        send_instruction(MODE_DIV, $urandom());
        send_instruction(MODE_MUL, $urandom());
        send_instruction(MODE_PUSH, DATA_W'(7));
        send_instruction(MODE_PUSH, DATA_W'(-2));
        send_instruction(MODE_DIV, $urandom());
        send_instruction(MODE_PUSH, MAX_VAL);
        send_instruction(MODE_MUL, $urandom());
        send_instruction(MODE_POP, $urandom());
        send_instruction(MODE_POP, $urandom());
        send_instruction(MODE_POP, $urandom());
        send_instruction(MODE_PUSH, 32'h5555_5555);
        send_instruction(MODE_SUB, $urandom());

        // Random at shallow depth, drain, then a second random stretch.
        send_random(400);
        wait_drained();

        send_random(425);
        wait_drained();

        repeat (60) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
